[rtl/mi_pkg.sv]
// Shared types and index tables for the 3x3 matrix inverse pipeline.
package mi_pkg;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

    typedef int t_idx_tab [0:17];

    // Operand pairs of the eighteen first-level products (element index row*3+col)
    localparam t_idx_tab MUL_A = '{4, 5, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam t_idx_tab MUL_B = '{8, 7, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

endpackage

[rtl/mi_front.sv]
// Product, adjugate and determinant stages of the matrix inverse pipeline.
module mi_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_a [0:8],
    output mi_pkg::t_ctl        o_ctl,
    output logic signed [W-1:0] o_adj [0:8],
    output logic signed [W-1:0] o_det
);

    localparam logic [2*W:0] HALF  = (2*W+1)'(1) << (F-1);
    localparam logic [2*W:0] LIM_P = (2*W+1)'({(W-1){1'b1}});
    localparam logic [2*W:0] LIM_N = LIM_P + (2*W+1)'(1);

    // Round a full product to F fraction bits, half away from zero, and saturate
    function automatic logic signed [W-1:0] rnd_sat(input logic signed [2*W-1:0] p);
        logic         neg;
        logic [2*W:0] mag;
        logic [2*W:0] m;
        logic [2*W:0] lim;
        begin
            neg = p[2*W-1];
            mag = neg ? (2*W+1)'(-{p[2*W-1], p}) : (2*W+1)'({1'b0, p});
            m   = (mag + HALF) >> F;
            lim = neg ? LIM_N : LIM_P;
            if (m > lim) begin
                m = lim;
            end
            rnd_sat = neg ? W'(-m) : W'(m);
        end
    endfunction

    // Saturate a W+1 bit difference to W bits
    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] d);
        begin
            if (d[W] != d[W-1]) begin
                sat1 = d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                sat1 = d[W-1:0];
            end
        end
    endfunction

    logic [4:0]                r_vld;
    logic signed [2*W-1:0]     r_p1 [0:17];
    logic signed [W-1:0]       r_c1 [0:8];
    logic signed [W-1:0]       r_q2 [0:17];
    logic signed [W-1:0]       r_c2 [0:8];
    logic signed [W-1:0]       r_adj3 [0:8];
    logic signed [2*W-1:0]     r_t3 [0:5];
    logic signed [W-1:0]       r_adj4 [0:8];
    logic signed [W-1:0]       r_t4 [0:5];
    logic signed [W-1:0]       r_adj5 [0:8];
    logic signed [W-1:0]       r_det5;
    logic signed [W+2:0]       n_sum;
    logic signed [W-1:0]       n_det;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Stage 1: eighteen full products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 18; k++) begin
                r_p1[k] <= i_a[mi_pkg::MUL_A[k]] * i_a[mi_pkg::MUL_B[k]];
            end
            r_c1 <= i_a;
        end
    end

    // Stage 2: round the products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 18; k++) begin
                r_q2[k] <= rnd_sat(r_p1[k]);
            end
            r_c2 <= r_c1;
        end
    end

    // Stage 3: adjugate differences and the triple products of the determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_adj3[k] <= sat1((W+1)'(r_q2[2*k]) - (W+1)'(r_q2[2*k+1]));
            end
            r_t3[0] <= r_q2[16] * r_c2[8];
            r_t3[1] <= r_q2[12] * r_c2[2];
            r_t3[2] <= r_q2[14] * r_c2[5];
            r_t3[3] <= r_q2[13] * r_c2[2];
            r_t3[4] <= r_q2[17] * r_c2[8];
            r_t3[5] <= r_q2[15] * r_c2[5];
        end
    end

    // Stage 4: round the triple products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_t4[k] <= rnd_sat(r_t3[k]);
            end
            r_adj4 <= r_adj3;
        end
    end

    // Stage 5: Sarrus sum, saturated
    always_comb begin
        n_sum = (W+3)'(r_t4[0]) + (W+3)'(r_t4[1]) + (W+3)'(r_t4[2])
              - (W+3)'(r_t4[3]) - (W+3)'(r_t4[4]) - (W+3)'(r_t4[5]);
        if (n_sum > (W+3)'(signed'({1'b0, {(W-1){1'b1}}}))) begin
            n_det = {1'b0, {(W-1){1'b1}}};
        end else if (n_sum < -(W+3)'(signed'({1'b0, {(W-1){1'b1}}})) - (W+3)'(1)) begin
            n_det = {1'b1, {(W-1){1'b0}}};
        end else begin
            n_det = n_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adj5 <= r_adj4;
            r_det5 <= n_det;
        end
    end

    assign o_ctl.valid    = r_vld[4];
    assign o_ctl.singular = (r_det5 == '0);
    assign o_adj          = r_adj5;
    assign o_det          = r_det5;

endmodule

[rtl/mi_divider.sv]
// Bit-per-stage restoring divider for nine adjugate entries over one determinant.
module mi_divider #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mi_pkg::t_ctl        i_ctl,
    input  logic signed [W-1:0] i_adj [0:8],
    input  logic signed [W-1:0] i_det,
    output mi_pkg::t_ctl        o_ctl,
    output logic signed [W-1:0] o_inv [0:8],
    output logic signed [W-1:0] o_det
);

    localparam int N = W + F;
    localparam logic [N:0] LIM_P = (N+1)'({(W-1){1'b1}});
    localparam logic [N:0] LIM_N = LIM_P + (N+1)'(1);

    mi_pkg::t_ctl        r_ctl [0:N];
    logic [W-1:0]        r_dv  [0:N];
    logic signed [W-1:0] r_det [0:N];
    logic                r_neg [0:N][0:8];
    logic [W-1:0]        r_rem [0:N][0:8];
    logic [N-1:0]        r_num [0:N][0:8];
    logic [N-1:0]        r_quo [0:N][0:8];
    mi_pkg::t_ctl        r_oct;
    logic signed [W-1:0] r_oinv [0:8];
    logic signed [W-1:0] r_odet;

    // Prepare magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0]  <= i_det[W-1] ? W'(-i_det) : W'(i_det);
            r_det[0] <= i_det;
            for (int l = 0; l < 9; l++) begin
                r_neg[0][l] <= i_adj[l][W-1] != i_det[W-1];
                r_rem[0][l] <= '0;
                r_num[0][l] <= (i_adj[l][W-1] ? N'(-{i_adj[l][W-1], i_adj[l]})
                                              : N'({1'b0, i_adj[l]})) << F;
                r_quo[0][l] <= '0;
            end
        end
    end

    // One quotient bit per stage
    for (genvar j = 0; j < N; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else if (i_en) begin
                r_ctl[j+1] <= r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [W:0] t;
            if (i_en) begin
                r_dv[j+1]  <= r_dv[j];
                r_det[j+1] <= r_det[j];
                for (int l = 0; l < 9; l++) begin
                    t = {r_rem[j][l], r_num[j][l][N-1]};
                    r_neg[j+1][l] <= r_neg[j][l];
                    r_num[j+1][l] <= r_num[j][l] << 1;
                    if (t >= {1'b0, r_dv[j]}) begin
                        r_rem[j+1][l] <= W'(t - {1'b0, r_dv[j]});
                        r_quo[j+1][l] <= {r_quo[j][l][N-2:0], 1'b1};
                    end else begin
                        r_rem[j+1][l] <= t[W-1:0];
                        r_quo[j+1][l] <= {r_quo[j][l][N-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Round, saturate and force zero on a singular matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct <= '0;
        end else if (i_en) begin
            r_oct <= r_ctl[N];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [N:0] q;
        logic [N:0] lim;
        if (i_en) begin
            r_odet <= r_det[N];
            for (int l = 0; l < 9; l++) begin
                q = {1'b0, r_quo[N][l]};
                if ({r_rem[N][l], 1'b0} >= {1'b0, r_dv[N]}) begin
                    q = q + (N+1)'(1);
                end
                lim = r_neg[N][l] ? LIM_N : LIM_P;
                if (q > lim) begin
                    q = lim;
                end
                if (r_ctl[N].singular) begin
                    r_oinv[l] <= '0;
                end else begin
                    r_oinv[l] <= r_neg[N][l] ? W'(-q) : W'(q);
                end
            end
        end
    end

    assign o_ctl = r_oct;
    assign o_inv = r_oinv;
    assign o_det = r_odet;

endmodule

[rtl/matrix_inverse_3x3.sv]
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
// Input channel: i_valid with the nine elements i_a00..i_a22 (signed, FRAC_BITS
// fraction bits); the block drives o_stall. A beat is taken at an edge where
// i_valid is high and o_stall is low.
// Output channel: o_valid with o_inv00..o_inv22, o_det_value and o_singular;
// the receiver drives i_stall. A beat is taken when o_valid is high and i_stall low.
// A beat passes through the products, rounding and the Sarrus sum, a register that
// prepares the divider, the restoring divider that forms the quotient bit by bit,
// and a final register that rounds and saturates.
// Throughput is one matrix per cycle unless stalled; every stage advances together.
// A singular matrix (determinant zero after rounding) gives zero inverse elements,
// a zero determinant and o_singular high.
// Reset clears all valid bits; o_valid falls on the cycle after reset.
// A stalled output beat moves into a one-beat skid register, which then drives the
// outputs steadily; from the next cycle o_stall is high and the whole pipeline holds
// until that beat is taken. o_stall never depends combinationally on i_stall.
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ELEM_WIDTH-1:0] i_a00,
    input  logic signed [ELEM_WIDTH-1:0] i_a01,
    input  logic signed [ELEM_WIDTH-1:0] i_a02,
    input  logic signed [ELEM_WIDTH-1:0] i_a10,
    input  logic signed [ELEM_WIDTH-1:0] i_a11,
    input  logic signed [ELEM_WIDTH-1:0] i_a12,
    input  logic signed [ELEM_WIDTH-1:0] i_a20,
    input  logic signed [ELEM_WIDTH-1:0] i_a21,
    input  logic signed [ELEM_WIDTH-1:0] i_a22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ELEM_WIDTH-1:0] o_inv00,
    output logic signed [ELEM_WIDTH-1:0] o_inv01,
    output logic signed [ELEM_WIDTH-1:0] o_inv02,
    output logic signed [ELEM_WIDTH-1:0] o_inv10,
    output logic signed [ELEM_WIDTH-1:0] o_inv11,
    output logic signed [ELEM_WIDTH-1:0] o_inv12,
    output logic signed [ELEM_WIDTH-1:0] o_inv20,
    output logic signed [ELEM_WIDTH-1:0] o_inv21,
    output logic signed [ELEM_WIDTH-1:0] o_inv22,
    output logic signed [ELEM_WIDTH-1:0] o_det_value,
    output logic                         o_singular
);

    logic                         en;
    logic signed [ELEM_WIDTH-1:0] a   [0:8];
    mi_pkg::t_ctl                 f_ctl;
    logic signed [ELEM_WIDTH-1:0] f_adj [0:8];
    logic signed [ELEM_WIDTH-1:0] f_det;
    mi_pkg::t_ctl                 d_ctl;
    logic signed [ELEM_WIDTH-1:0] d_inv [0:8];
    logic signed [ELEM_WIDTH-1:0] d_det;
    logic                         r_sk_vld;
    logic                         r_sk_sing;
    logic signed [ELEM_WIDTH-1:0] r_sk_inv [0:8];
    logic signed [ELEM_WIDTH-1:0] r_sk_det;
    logic signed [ELEM_WIDTH-1:0] out_inv [0:8];

    // Hold everything while the skid register carries a beat
    assign en      = !r_sk_vld;
    assign o_stall = r_sk_vld;

    assign a[0] = i_a00;
    assign a[1] = i_a01;
    assign a[2] = i_a02;
    assign a[3] = i_a10;
    assign a[4] = i_a11;
    assign a[5] = i_a12;
    assign a[6] = i_a20;
    assign a[7] = i_a21;
    assign a[8] = i_a22;

    mi_front #(.W(ELEM_WIDTH), .F(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (a),
        .o_ctl   (f_ctl),
        .o_adj   (f_adj),
        .o_det   (f_det)
    );

    mi_divider #(.W(ELEM_WIDTH), .F(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (f_ctl),
        .i_adj   (f_adj),
        .i_det   (f_det),
        .o_ctl   (d_ctl),
        .o_inv   (d_inv),
        .o_det   (d_det)
    );

    // Park a stalled output beat; release it once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (!i_stall) begin
                r_sk_vld <= 1'b0;
            end
        end else if (d_ctl.valid && i_stall) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_inv  <= d_inv;
            r_sk_det  <= d_det;
            r_sk_sing <= d_ctl.singular;
        end
    end

    // Drive the outputs from the skid register while it is full
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            out_inv[k] = r_sk_vld ? r_sk_inv[k] : d_inv[k];
        end
    end

    assign o_valid     = r_sk_vld || d_ctl.valid;
    assign o_singular  = r_sk_vld ? r_sk_sing : d_ctl.singular;
    assign o_det_value = r_sk_vld ? r_sk_det : d_det;
    assign o_inv00     = out_inv[0];
    assign o_inv01     = out_inv[1];
    assign o_inv02     = out_inv[2];
    assign o_inv10     = out_inv[3];
    assign o_inv11     = out_inv[4];
    assign o_inv12     = out_inv[5];
    assign o_inv20     = out_inv[6];
    assign o_inv21     = out_inv[7];
    assign o_inv22     = out_inv[8];

    // A singular beat carries zeros in inverse elements 00, 11, 22, 01, 12 and 20
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_inv00 == '0 && o_inv11 == '0 && o_inv22 == '0
                                     && o_inv01 == '0 && o_inv12 == '0 && o_inv20 == '0))
        else $error("singular beat with nonzero inverse");

    // The flag matches the determinant
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_singular == (o_det_value == '0)))
        else $error("singular flag disagrees with determinant");

    // A stalled output beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_det_value) && $stable(o_inv00)))
        else $error("stalled output beat changed");

endmodule

[test/tb_matrix_inverse_3x3.sv]
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
module tb_matrix_inverse_3x3;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int LATENCY    = ELEM_WIDTH + FRAC_BITS + 7;
    localparam longint ONE    = 64'sd1 << FRAC_BITS;
    localparam longint EMAX   = (64'sd1 <<< (ELEM_WIDTH - 1)) - 1;
    localparam longint EMIN   = -EMAX - 1;
    localparam int HOLD_CYCLES = 400;

    typedef logic [8:0][ELEM_WIDTH-1:0] t_matrix;

    typedef struct packed {
        logic [8:0][ELEM_WIDTH-1:0] inv;
        logic [ELEM_WIDTH-1:0]      det;
        logic                       sing;
    } t_inverse;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [ELEM_WIDTH-1:0] elem [9] = '{default: '0};
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [ELEM_WIDTH-1:0] inv_o [9];
    logic signed [ELEM_WIDTH-1:0] det_o;
    logic                         sing_o;

    t_inverse pending_inverses [$];
    int       errors = 0;
    int       sent = 0;
    int       checked = 0;
    int       singular_seen = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       hold_req = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    matrix_inverse_3x3 #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(ELEM_WIDTH)) u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_a00(elem[0]), .i_a01(elem[1]), .i_a02(elem[2]),
        .i_a10(elem[3]), .i_a11(elem[4]), .i_a12(elem[5]),
        .i_a20(elem[6]), .i_a21(elem[7]), .i_a22(elem[8]),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_inv00(inv_o[0]), .o_inv01(inv_o[1]), .o_inv02(inv_o[2]),
        .o_inv10(inv_o[3]), .o_inv11(inv_o[4]), .o_inv12(inv_o[5]),
        .o_inv20(inv_o[6]), .o_inv21(inv_o[7]), .o_inv22(inv_o[8]),
        .o_det_value(det_o), .o_singular(sing_o)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturate an exact value to the element range
    function automatic longint sat_elem(input longint x);
        if (x > EMAX) return EMAX;
        if (x < EMIN) return EMIN;
        return x;
    endfunction

    // Magnitude and sign back to a saturated element
    function automatic longint pack_signed(input bit neg, input longint unsigned m);
        longint unsigned lim;
        lim = neg ? longint'(EMAX) + 1 : longint'(EMAX);
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Fixed-point product, rounded half away from zero, saturated
    function automatic longint fx_mul(input longint x, input longint y);
        longint unsigned mx, my, m;
        mx = x < 0 ? -x : x;
        my = y < 0 ? -y : y;
        m = (mx * my + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return pack_signed((x < 0) != (y < 0), m);
    endfunction

    // Fixed-point quotient, rounded half away from zero, saturated
    function automatic longint fx_div(input longint n, input longint d);
        longint unsigned num, dv, q, r;
        num = (n < 0 ? -n : n) << FRAC_BITS;
        dv  = d < 0 ? -d : d;
        q = num / dv;
        r = num % dv;
        if (2 * r >= dv) q++;
        return pack_signed((n < 0) != (d < 0), q);
    endfunction

    function automatic t_inverse predict_inverse(input t_matrix m);
        longint   e [9];
        longint   adj [9];
        longint   det;
        t_inverse res;
        for (int k = 0; k < 9; k++) e[k] = longint'(signed'(m[k]));
        adj[0] = sat_elem(fx_mul(e[4], e[8]) - fx_mul(e[5], e[7]));
        adj[1] = sat_elem(fx_mul(e[7], e[2]) - fx_mul(e[1], e[8]));
        adj[2] = sat_elem(fx_mul(e[1], e[5]) - fx_mul(e[4], e[2]));
        adj[3] = sat_elem(fx_mul(e[6], e[5]) - fx_mul(e[3], e[8]));
        adj[4] = sat_elem(fx_mul(e[0], e[8]) - fx_mul(e[6], e[2]));
        adj[5] = sat_elem(fx_mul(e[3], e[2]) - fx_mul(e[0], e[5]));
        adj[6] = sat_elem(fx_mul(e[3], e[7]) - fx_mul(e[6], e[4]));
        adj[7] = sat_elem(fx_mul(e[6], e[1]) - fx_mul(e[0], e[7]));
        adj[8] = sat_elem(fx_mul(e[0], e[4]) - fx_mul(e[3], e[1]));
        det = sat_elem(fx_mul(fx_mul(e[0], e[4]), e[8]) + fx_mul(fx_mul(e[3], e[7]), e[2])
                     + fx_mul(fx_mul(e[6], e[1]), e[5]) - fx_mul(fx_mul(e[6], e[4]), e[2])
                     - fx_mul(fx_mul(e[3], e[1]), e[8]) - fx_mul(fx_mul(e[0], e[7]), e[5]));
        res.sing = (det == 0);
        res.det  = det[ELEM_WIDTH-1:0];
        for (int k = 0; k < 9; k++)
            res.inv[k] = res.sing ? '0 : ELEM_WIDTH'(fx_div(adj[k], det));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [ELEM_WIDTH-1:0] got,
                                   input logic [ELEM_WIDTH-1:0] want);
        $display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
        errors++;
    endtask

    // Offer one matrix, with random idle cycles first, and hold it until taken
    task automatic send_matrix(input t_matrix m);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++) elem[k] <= m[k];
        do @(posedge clk); while (in_stall);
        pending_inverses.push_back(predict_inverse(m));
        sent++;
    endtask

    // Check each output beat against the oldest prediction
    always @(posedge clk) begin
        t_inverse want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_inverses.size() == 0) begin
                report_mismatch("unexpected beat", det_o, '0);
            end else begin
                want = pending_inverses.pop_front();
                for (int k = 0; k < 9; k++)
                    if (inv_o[k] !== want.inv[k])
                        report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                        inv_o[k], want.inv[k]);
                if (det_o !== want.det) report_mismatch("det_value", det_o, want.det);
                if (sing_o !== want.sing)
                    report_mismatch("singular", ELEM_WIDTH'(sing_o), ELEM_WIDTH'(want.sing));
                if (want.sing) singular_seen++;
                checked++;
            end
        end
    end

    // Drive the receiver stall, with a counted long hold on request
    always @(posedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic logic [ELEM_WIDTH-1:0] rand_small(input int bits);
        longint v;
        v = longint'($urandom_range((1 << bits) - 1)) - (longint'(1) << (bits - 1));
        return v[ELEM_WIDTH-1:0];
    endfunction

    // Random matrix: mostly well-conditioned content, some singular, some raw
    function automatic t_matrix rand_matrix();
        t_matrix m;
        int      mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 9; k++) m[k] = rand_small(19);
        case (mode)
            0, 1, 2, 3: ;
            4: begin
                for (int k = 0; k < 9; k++) m[k] = rand_small(14);
                for (int k = 0; k < 9; k += 4) m[k] = ELEM_WIDTH'(ONE + rand_small(15));
            end
            5: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
            6: for (int k = 0; k < 9; k++) m[k] = $urandom;
            7: for (int k = 0; k < 9; k++) m[k] = rand_small(10);
            8: for (int k = 0; k < 9; k++) m[k] = rand_small(26);
            default: begin
                for (int k = 0; k < 9; k++) m[k] = rand_small(8);
                for (int k = 0; k < 9; k += 4) m[k] = rand_small(19);
            end
        endcase
        return m;
    endfunction

    function automatic t_matrix fill_matrix(input longint v);
        t_matrix m;
        for (int k = 0; k < 9; k++) m[k] = ELEM_WIDTH'(v);
        return m;
    endfunction

    function automatic t_matrix diag_matrix(input longint v);
        t_matrix m;
        m = '0;
        m[0] = ELEM_WIDTH'(v); m[4] = ELEM_WIDTH'(v); m[8] = ELEM_WIDTH'(v);
        return m;
    endfunction

    task automatic test_directed();
        t_matrix m;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_matrix(diag_matrix(ONE));
        send_matrix('0);
        send_matrix(fill_matrix(ONE));
        send_matrix(fill_matrix(EMAX));
        send_matrix(fill_matrix(EMIN));
        send_matrix(diag_matrix(EMAX));
        send_matrix(diag_matrix(EMIN));
        send_matrix(diag_matrix(-ONE));
        send_matrix(diag_matrix(2 * ONE));
        send_matrix(diag_matrix(1));
        send_matrix(diag_matrix(ONE >> 4));
        send_matrix(diag_matrix(ONE << 6));
        send_matrix(fill_matrix(-1));
        m = diag_matrix(EMAX); m[1] = ELEM_WIDTH'(EMIN); m[5] = ELEM_WIDTH'(EMIN);
        m[6] = ELEM_WIDTH'(EMAX);
        send_matrix(m);
        m = diag_matrix(EMIN); m[2] = ELEM_WIDTH'(EMAX); m[3] = ELEM_WIDTH'(EMAX);
        m[7] = ELEM_WIDTH'(EMIN);
        send_matrix(m);
        m = '0; m[2] = ELEM_WIDTH'(ONE); m[4] = ELEM_WIDTH'(ONE); m[6] = ELEM_WIDTH'(ONE);
        send_matrix(m);
        m = '0; m[0] = ELEM_WIDTH'(3 * ONE); m[1] = ELEM_WIDTH'(ONE); m[3] = ELEM_WIDTH'(ONE);
        m[4] = ELEM_WIDTH'(2 * ONE); m[8] = ELEM_WIDTH'(-ONE / 2);
        send_matrix(m);
        m = fill_matrix(32'h5555_5555); m[4] = 32'hAAAA_AAAA;
        send_matrix(m);
        m = fill_matrix(32'hAAAA_AAAA); m[0] = 32'h5555_5555;
        send_matrix(m);
        send_matrix(diag_matrix(ONE >> 9));
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        tx_idle_pct = idle;
        rx_stall_pct = stall;
        repeat (count) send_matrix(rand_matrix());
    endtask

    // Hold the receiver off for a long stretch while matrices keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req++;
        repeat (LATENCY * 2) send_matrix(rand_matrix());
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_inverses.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        if (pending_inverses.size() != 0) begin
            $display("%0d results never arrived", pending_inverses.size());
            errors++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(110, 0, 0);
        test_random(110, 59, 0);
        test_random(110, 0, 59);
        test_random(110, 25, 25);
        test_backpressure();
        test_random(30, 25, 25);
        drain();
        $display("sent %0d matrices, checked %0d inverses (%0d singular)",
                 sent, checked, singular_seen);
        $display("covered extremes, singular cases, random stalls and a long output hold");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
